FILE: rtl/actc_pkg.sv
// ----------------------------------------------------------------------------
// actc_pkg: shared types, constants and AES helper functions
// AES-128 round primitives and CCM block layout constants.
// ----------------------------------------------------------------------------
`default_nettype none
package actc_pkg;

    localparam logic [7:0] A0_FLAG   = 8'h01;
    localparam logic [7:0] B0_FLAG   = 8'h49;
    localparam logic [15:0] AAD_LEN  = 16'd9;
    localparam int         NUM_ROUNDS = 10;

    typedef logic [127:0] block_t;

    typedef struct packed {
        logic [63:0]  key_high;
        logic [63:0]  key_low;
        logic [47:0]  device_address;
        logic [31:0]  sequence_counter;
        logic [7:0]   telegram_length;
        logic [7:0]   ad_type;
        logic [15:0]  manufacturer_id;
        logic [7:0]   switch_status;
        logic [31:0]  received_signature;
    } item_t;

    function automatic logic [7:0] sbox(input logic [7:0] x);
        logic [7:0] r;
        case (x)
            8'h00: r=8'h63; 8'h01: r=8'h7c; 8'h02: r=8'h77; 8'h03: r=8'h7b;
            8'h04: r=8'hf2; 8'h05: r=8'h6b; 8'h06: r=8'h6f; 8'h07: r=8'hc5;
            8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0a: r=8'h67; 8'h0b: r=8'h2b;
            8'h0c: r=8'hfe; 8'h0d: r=8'hd7; 8'h0e: r=8'hab; 8'h0f: r=8'h76;
            8'h10: r=8'hca; 8'h11: r=8'h82; 8'h12: r=8'hc9; 8'h13: r=8'h7d;
            8'h14: r=8'hfa; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hf0;
            8'h18: r=8'had; 8'h19: r=8'hd4; 8'h1a: r=8'ha2; 8'h1b: r=8'haf;
            8'h1c: r=8'h9c; 8'h1d: r=8'ha4; 8'h1e: r=8'h72; 8'h1f: r=8'hc0;
            8'h20: r=8'hb7; 8'h21: r=8'hfd; 8'h22: r=8'h93; 8'h23: r=8'h26;
            8'h24: r=8'h36; 8'h25: r=8'h3f; 8'h26: r=8'hf7; 8'h27: r=8'hcc;
            8'h28: r=8'h34; 8'h29: r=8'ha5; 8'h2a: r=8'he5; 8'h2b: r=8'hf1;
            8'h2c: r=8'h71; 8'h2d: r=8'hd8; 8'h2e: r=8'h31; 8'h2f: r=8'h15;
            8'h30: r=8'h04; 8'h31: r=8'hc7; 8'h32: r=8'h23; 8'h33: r=8'hc3;
            8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9a;
            8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3a: r=8'h80; 8'h3b: r=8'he2;
            8'h3c: r=8'heb; 8'h3d: r=8'h27; 8'h3e: r=8'hb2; 8'h3f: r=8'h75;
            8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2c; 8'h43: r=8'h1a;
            8'h44: r=8'h1b; 8'h45: r=8'h6e; 8'h46: r=8'h5a; 8'h47: r=8'ha0;
            8'h48: r=8'h52; 8'h49: r=8'h3b; 8'h4a: r=8'hd6; 8'h4b: r=8'hb3;
            8'h4c: r=8'h29; 8'h4d: r=8'he3; 8'h4e: r=8'h2f; 8'h4f: r=8'h84;
            8'h50: r=8'h53; 8'h51: r=8'hd1; 8'h52: r=8'h00; 8'h53: r=8'hed;
            8'h54: r=8'h20; 8'h55: r=8'hfc; 8'h56: r=8'hb1; 8'h57: r=8'h5b;
            8'h58: r=8'h6a; 8'h59: r=8'hcb; 8'h5a: r=8'hbe; 8'h5b: r=8'h39;
            8'h5c: r=8'h4a; 8'h5d: r=8'h4c; 8'h5e: r=8'h58; 8'h5f: r=8'hcf;
            8'h60: r=8'hd0; 8'h61: r=8'hef; 8'h62: r=8'haa; 8'h63: r=8'hfb;
            8'h64: r=8'h43; 8'h65: r=8'h4d; 8'h66: r=8'h33; 8'h67: r=8'h85;
            8'h68: r=8'h45; 8'h69: r=8'hf9; 8'h6a: r=8'h02; 8'h6b: r=8'h7f;
            8'h6c: r=8'h50; 8'h6d: r=8'h3c; 8'h6e: r=8'h9f; 8'h6f: r=8'ha8;
            8'h70: r=8'h51; 8'h71: r=8'ha3; 8'h72: r=8'h40; 8'h73: r=8'h8f;
            8'h74: r=8'h92; 8'h75: r=8'h9d; 8'h76: r=8'h38; 8'h77: r=8'hf5;
            8'h78: r=8'hbc; 8'h79: r=8'hb6; 8'h7a: r=8'hda; 8'h7b: r=8'h21;
            8'h7c: r=8'h10; 8'h7d: r=8'hff; 8'h7e: r=8'hf3; 8'h7f: r=8'hd2;
            8'h80: r=8'hcd; 8'h81: r=8'h0c; 8'h82: r=8'h13; 8'h83: r=8'hec;
            8'h84: r=8'h5f; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
            8'h88: r=8'hc4; 8'h89: r=8'ha7; 8'h8a: r=8'h7e; 8'h8b: r=8'h3d;
            8'h8c: r=8'h64; 8'h8d: r=8'h5d; 8'h8e: r=8'h19; 8'h8f: r=8'h73;
            8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4f; 8'h93: r=8'hdc;
            8'h94: r=8'h22; 8'h95: r=8'h2a; 8'h96: r=8'h90; 8'h97: r=8'h88;
            8'h98: r=8'h46; 8'h99: r=8'hee; 8'h9a: r=8'hb8; 8'h9b: r=8'h14;
            8'h9c: r=8'hde; 8'h9d: r=8'h5e; 8'h9e: r=8'h0b; 8'h9f: r=8'hdb;
            8'ha0: r=8'he0; 8'ha1: r=8'h32; 8'ha2: r=8'h3a; 8'ha3: r=8'h0a;
            8'ha4: r=8'h49; 8'ha5: r=8'h06; 8'ha6: r=8'h24; 8'ha7: r=8'h5c;
            8'ha8: r=8'hc2; 8'ha9: r=8'hd3; 8'haa: r=8'hac; 8'hab: r=8'h62;
            8'hac: r=8'h91; 8'had: r=8'h95; 8'hae: r=8'he4; 8'haf: r=8'h79;
            8'hb0: r=8'he7; 8'hb1: r=8'hc8; 8'hb2: r=8'h37; 8'hb3: r=8'h6d;
            8'hb4: r=8'h8d; 8'hb5: r=8'hd5; 8'hb6: r=8'h4e; 8'hb7: r=8'ha9;
            8'hb8: r=8'h6c; 8'hb9: r=8'h56; 8'hba: r=8'hf4; 8'hbb: r=8'hea;
            8'hbc: r=8'h65; 8'hbd: r=8'h7a; 8'hbe: r=8'hae; 8'hbf: r=8'h08;
            8'hc0: r=8'hba; 8'hc1: r=8'h78; 8'hc2: r=8'h25; 8'hc3: r=8'h2e;
            8'hc4: r=8'h1c; 8'hc5: r=8'ha6; 8'hc6: r=8'hb4; 8'hc7: r=8'hc6;
            8'hc8: r=8'he8; 8'hc9: r=8'hdd; 8'hca: r=8'h74; 8'hcb: r=8'h1f;
            8'hcc: r=8'h4b; 8'hcd: r=8'hbd; 8'hce: r=8'h8b; 8'hcf: r=8'h8a;
            8'hd0: r=8'h70; 8'hd1: r=8'h3e; 8'hd2: r=8'hb5; 8'hd3: r=8'h66;
            8'hd4: r=8'h48; 8'hd5: r=8'h03; 8'hd6: r=8'hf6; 8'hd7: r=8'h0e;
            8'hd8: r=8'h61; 8'hd9: r=8'h35; 8'hda: r=8'h57; 8'hdb: r=8'hb9;
            8'hdc: r=8'h86; 8'hdd: r=8'hc1; 8'hde: r=8'h1d; 8'hdf: r=8'h9e;
            8'he0: r=8'he1; 8'he1: r=8'hf8; 8'he2: r=8'h98; 8'he3: r=8'h11;
            8'he4: r=8'h69; 8'he5: r=8'hd9; 8'he6: r=8'h8e; 8'he7: r=8'h94;
            8'he8: r=8'h9b; 8'he9: r=8'h1e; 8'hea: r=8'h87; 8'heb: r=8'he9;
            8'hec: r=8'hce; 8'hed: r=8'h55; 8'hee: r=8'h28; 8'hef: r=8'hdf;
            8'hf0: r=8'h8c; 8'hf1: r=8'ha1; 8'hf2: r=8'h89; 8'hf3: r=8'h0d;
            8'hf4: r=8'hbf; 8'hf5: r=8'he6; 8'hf6: r=8'h42; 8'hf7: r=8'h68;
            8'hf8: r=8'h41; 8'hf9: r=8'h99; 8'hfa: r=8'h2d; 8'hfb: r=8'h0f;
            8'hfc: r=8'hb0; 8'hfd: r=8'h54; 8'hfe: r=8'hbb; 8'hff: r=8'h16;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] rcon(input logic [3:0] rnd);
        logic [7:0] r;
        case (rnd)
            4'd1: r = 8'h01;  4'd2: r = 8'h02;  4'd3: r = 8'h04;  4'd4: r = 8'h08;
            4'd5: r = 8'h10;  4'd6: r = 8'h20;  4'd7: r = 8'h40;  4'd8: r = 8'h80;
            4'd9: r = 8'h1b;  4'd10: r = 8'h36;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    // Byte i of a block sits at bits [127-8i -: 8].
    function automatic logic [127:0] next_round_key(input logic [127:0] k,
                                                    input logic [3:0] rnd);
        logic [31:0] w0, w1, w2, w3, t;
        w0 = k[127:96];
        w1 = k[95:64];
        w2 = k[63:32];
        w3 = k[31:0];
        t  = {sbox(w3[23:16]) ^ rcon(rnd), sbox(w3[15:8]), sbox(w3[7:0]),
              sbox(w3[31:24])};
        w0 = w0 ^ t;
        w1 = w1 ^ w0;
        w2 = w2 ^ w1;
        w3 = w3 ^ w2;
        return {w0, w1, w2, w3};
    endfunction

    // SubBytes, ShiftRows and optional MixColumns (round key added by caller).
    function automatic logic [127:0] round_core(input logic [127:0] s,
                                                input logic mix);
        logic [7:0] t [16];
        logic [7:0] a0, a1, a2, a3, all;
        logic [127:0] o;
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
                t[4*c+r] = sbox(s[127-8*(4*((c+r)%4)+r) -: 8]);
        for (int c = 0; c < 4; c++) begin
            a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
            all = a0 ^ a1 ^ a2 ^ a3;
            if (mix) begin
                t[4*c]   = a0 ^ all ^ xtime(a0 ^ a1);
                t[4*c+1] = a1 ^ all ^ xtime(a1 ^ a2);
                t[4*c+2] = a2 ^ all ^ xtime(a2 ^ a3);
                t[4*c+3] = a3 ^ all ^ xtime(a3 ^ a0);
            end
        end
        for (int i = 0; i < 16; i++)
            o[127-8*i -: 8] = t[i];
        return o;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/actc_stream_if.sv
// ----------------------------------------------------------------------------
// actc_stream_if: valid/ready channel
// Carries one payload of type PAYLOAD_T per transfer.
// ----------------------------------------------------------------------------
`default_nettype none
interface actc_stream_if #(parameter type PAYLOAD_T = logic);
    logic     valid;
    logic     ready;
    PAYLOAD_T data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: rtl/actc_pipe.sv
// ----------------------------------------------------------------------------
// actc_pipe: three-lane AES-128 CCM pipeline
// Stages 0..9 run rounds 1..10 of AES(B0) and AES(A0) with on-the-fly key
// expansion; stage 10 forms X1, stages 11..20 run AES(X1), stage 21 tags.
// ----------------------------------------------------------------------------
`default_nettype none
module actc_pipe (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 advance,
    input  wire logic                 in_valid,
    input  wire actc_pkg::item_t      in_item,
    output logic                      out_valid,
    output logic [31:0]               out_tag,
    output logic                      out_ok
);
    localparam int DEPTH = 2 * actc_pkg::NUM_ROUNDS + 2;

    typedef struct packed {
        logic [127:0] key;    // cipher key, reused for the X1 pass
        logic [127:0] rk;
        logic [127:0] sa;     // B0 chain, then X1 chain
        logic [127:0] sb;     // A0 chain (S0)
        logic [127:0] b1;
        logic [31:0]  sig;
    } lane_t;

    lane_t              st_reg   [DEPTH];
    lane_t              st_next  [DEPTH];
    logic [DEPTH-1:0]   vld_reg;

    // Input formatting; the initial AddRoundKey is applied in stage 0.
    logic [127:0] in_key;
    logic [103:0] nonce;
    logic [127:0] a0_blk, b0_blk, b1_blk;
    always_comb
    begin
        in_key = {in_item.key_high, in_item.key_low};
        for (int i = 0; i < 6; i++)
            nonce[103-8*i -: 8] = in_item.device_address[8*i +: 8];
        for (int i = 0; i < 4; i++)
            nonce[55-8*i -: 8] = in_item.sequence_counter[8*i +: 8];
        nonce[23:0] = 24'h0;
        a0_blk = {actc_pkg::A0_FLAG, nonce, 16'h0};
        b0_blk = {actc_pkg::B0_FLAG, nonce, 16'h0};
        b1_blk = {actc_pkg::AAD_LEN, in_item.telegram_length, in_item.ad_type,
                  in_item.manufacturer_id[7:0], in_item.manufacturer_id[15:8],
                  in_item.sequence_counter[7:0], in_item.sequence_counter[15:8],
                  in_item.sequence_counter[23:16], in_item.sequence_counter[31:24],
                  in_item.switch_status, 40'h0};
    end

    always_comb
    begin
        logic [127:0] k;
        logic [3:0]   rnd;
        for (int s = 1; s < DEPTH; s++)
            st_next[s] = st_reg[s-1];
        // stage 0: round 1 of both first-pass chains
        k = actc_pkg::next_round_key(in_key, 4'd1);
        st_next[0].key = in_key;
        st_next[0].rk  = k;
        st_next[0].sa  = actc_pkg::round_core(b0_blk ^ in_key, 1'b1) ^ k;
        st_next[0].sb  = actc_pkg::round_core(a0_blk ^ in_key, 1'b1) ^ k;
        st_next[0].b1  = b1_blk;
        st_next[0].sig = in_item.received_signature;
        for (int s = 1; s < 10; s++) begin
            rnd = 4'(s + 1);
            k = actc_pkg::next_round_key(st_reg[s-1].rk, rnd);
            st_next[s].rk = k;
            st_next[s].sa = actc_pkg::round_core(st_reg[s-1].sa, rnd != 4'd10) ^ k;
            st_next[s].sb = actc_pkg::round_core(st_reg[s-1].sb, rnd != 4'd10) ^ k;
        end
        // stage 10: X1 = AES(B0) ^ B1, then initial key add with the carried key
        st_next[10].sa = st_reg[9].sa ^ st_reg[9].b1 ^ st_reg[9].key;
        st_next[10].rk = st_reg[9].key;
        for (int s = 11; s < 21; s++) begin
            rnd = 4'(s - 10);
            k = actc_pkg::next_round_key(st_reg[s-1].rk, rnd);
            st_next[s].rk = k;
            st_next[s].sa = actc_pkg::round_core(st_reg[s-1].sa, rnd != 4'd10) ^ k;
        end
        st_next[21].sa = st_reg[20].sa ^ st_reg[20].sb;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (advance)
            vld_reg <= {vld_reg[DEPTH-2:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            for (int s = 0; s < DEPTH; s++)
                st_reg[s] <= st_next[s];
    end

    assign out_valid = vld_reg[DEPTH-1];
    assign out_tag   = st_reg[DEPTH-1].sa[127:96];
    assign out_ok    = (st_reg[DEPTH-1].sa[127:96] == st_reg[DEPTH-1].sig);

    property p_hold;
        @(posedge clk) disable iff (!rst_n) !advance |=> $stable(vld_reg);
    endproperty
    a_hold: assert property (p_hold) else $error("pipe moved while stalled");

    property p_shift;
        @(posedge clk) disable iff (!rst_n)
            advance |=> vld_reg[DEPTH-1] == $past(vld_reg[DEPTH-2]);
    endproperty
    a_shift: assert property (p_shift) else $error("valid lost in pipe");

    property p_ok;
        @(posedge clk) disable iff (!rst_n)
            out_valid |-> out_ok == (out_tag == st_reg[DEPTH-1].sig);
    endproperty
    a_ok: assert property (p_ok) else $error("match flag wrong");

endmodule
`default_nettype wire

FILE: rtl/aes_ccm_telegram_tag_check.sv
// ----------------------------------------------------------------------------
// aes_ccm_telegram_tag_check: AES-128 CCM 4-byte MIC check
// Computes the telegram tag and compares it with the received signature.
// ----------------------------------------------------------------------------
//  channel   dir   payload
//  in_ch     in    key_high key_low device_address sequence_counter
//                  telegram_length ad_type manufacturer_id switch_status
//                  received_signature
//  out_ch    out   signature_ok computed_tag
//
//  One transfer per cycle sustained while the result channel is not stalled;
//  22 register stages. The depth is set by 20 AES rounds, one per stage,
//  plus the X1 formation stage and the tag stage.
//  Reset clears only the stage valid bits; data registers are not reset.
//  The whole pipe advances when the output stage is empty or being taken,
//  so a stall freezes every stage and nothing is lost or repeated.
// ----------------------------------------------------------------------------
`default_nettype none
module aes_ccm_telegram_tag_check (
    input  wire logic clk,
    input  wire logic rst_n,
    actc_stream_if.sink   in_ch,
    actc_stream_if.source out_ch
);
    logic                advance;
    logic                pipe_valid;
    logic [31:0]         pipe_tag;
    logic                pipe_ok;
    actc_pkg::item_t     item;

    // Pipe moves when its last stage is free or its result is taken.
    assign advance     = !pipe_valid || out_ch.ready;
    assign in_ch.ready = advance;

    always_comb
    begin
        item.key_high           = in_ch.data.key_high;
        item.key_low            = in_ch.data.key_low;
        item.device_address     = in_ch.data.device_address;
        item.sequence_counter   = in_ch.data.sequence_counter;
        item.telegram_length    = in_ch.data.telegram_length;
        item.ad_type            = in_ch.data.ad_type;
        item.manufacturer_id    = in_ch.data.manufacturer_id;
        item.switch_status      = in_ch.data.switch_status;
        item.received_signature = in_ch.data.received_signature;
    end

    actc_pipe u_pipe (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .in_valid  (in_ch.valid),
        .in_item   (item),
        .out_valid (pipe_valid),
        .out_tag   (pipe_tag),
        .out_ok    (pipe_ok)
    );

    assign out_ch.valid             = pipe_valid;
    assign out_ch.data.computed_tag = pipe_tag;
    assign out_ch.data.signature_ok = pipe_ok;

    property p_ready;
        @(posedge clk) disable iff (!rst_n) !out_ch.valid |-> in_ch.ready;
    endproperty
    a_ready: assert property (p_ready) else $error("empty pipe refused input");

    property p_stall;
        @(posedge clk) disable iff (!rst_n)
            out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data);
    endproperty
    a_stall: assert property (p_stall) else $error("result dropped on stall");

    property p_link;
        @(posedge clk) disable iff (!rst_n) in_ch.ready == advance;
    endproperty
    a_link: assert property (p_link) else $error("ready not tied to advance");

endmodule
`default_nettype wire

FILE: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for aes_ccm_telegram_tag_check
// Drives switch telegrams through the valid/ready input channel with random
// gaps, and stalls the result channel at random. Every accepted telegram is
// run through a local AES-128 CCM model. Each result is compared in order
// with the tag that the model predicts.
// ----------------------------------------------------------------------------
`default_nettype none
module testbench;

    // Result payload: signature_ok above computed_tag.
    typedef struct packed {
        logic        signature_ok;
        logic [31:0] computed_tag;
    } result_t;

    // One row of the directed table.
    typedef struct {
        actc_pkg::item_t tlg;
        bit    good_sig;   // replace received_signature with the true tag
    } telegram_row_t;

    localparam int RANDOM_TELEGRAMS = 430;
    localparam int DRAIN_CYCLES     = 40;   // beyond the pipe depth
    localparam int MAX_WAIT         = 8;

    logic clk;
    logic rst_n;

    actc_stream_if #(.PAYLOAD_T(actc_pkg::item_t)) in_ch ();
    actc_stream_if #(.PAYLOAD_T(result_t))         out_ch ();

    aes_ccm_telegram_tag_check u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    // Local S-box, built from the GF(2^8) inverse and the affine map.
    logic [7:0] sb [256];

    result_t   expected_tags [$];
    int        mismatches;
    int        tags_seen;
    int        tags_matched;
    int        telegrams_sent;
    bit        no_idle;          // burst phase: neither side idles
    int        out_stall;

    // ------------------------------------------------------------------------
    // Clock and reset
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        #2000000;
        $display("testbench NOT OK");
        $finish;
    end

    // ------------------------------------------------------------------------
    // AES-128 model
    // ------------------------------------------------------------------------
    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] p;
        p = 8'h00;
        for (int i = 0; i < 8; i++)
        begin
            if (b[i])
                p ^= a;
            a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
        end
        return p;
    endfunction

    function automatic logic [7:0] dbl(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] rotl8(input logic [7:0] x, input int n);
        return (x << n) | (x >> (8 - n));
    endfunction

    initial
    begin
        logic [7:0] inv;
        for (int x = 0; x < 256; x++)
        begin
            inv = 8'h00;
            for (int y = 1; y < 256; y++)
                if (gf_mul(x[7:0], y[7:0]) == 8'h01)
                    inv = y[7:0];
            sb[x] = inv ^ rotl8(inv, 1) ^ rotl8(inv, 2) ^ rotl8(inv, 3)
                  ^ rotl8(inv, 4) ^ 8'h63;
        end
    end

    // Byte i of a 128-bit vector sits at [127-8i -: 8].
    function automatic logic [127:0] aes_encrypt(input logic [127:0] key,
                                                 input logic [127:0] blk);
        logic [7:0] rk [16];
        logic [7:0] st [16];
        logic [7:0] t  [16];
        logic [7:0] tw [4];
        logic [7:0] rc, a0, a1, a2, a3, all;
        logic [127:0] o;
        rc = 8'h01;
        for (int i = 0; i < 16; i++)
        begin
            rk[i] = key[127-8*i -: 8];
            st[i] = blk[127-8*i -: 8] ^ rk[i];
        end
        for (int rnd = 1; rnd <= 10; rnd++)
        begin
            // next round key
            tw[0] = sb[rk[13]] ^ rc;
            tw[1] = sb[rk[14]];
            tw[2] = sb[rk[15]];
            tw[3] = sb[rk[12]];
            rc = dbl(rc);
            for (int w = 0; w < 4; w++)
                for (int b = 0; b < 4; b++)
                begin
                    rk[4*w+b] ^= (w == 0) ? tw[b] : rk[4*(w-1)+b];
                end
            for (int c = 0; c < 4; c++)
                for (int r = 0; r < 4; r++)
                    t[4*c+r] = sb[st[4*((c+r)%4)+r]];
            if (rnd != 10)
                for (int c = 0; c < 4; c++)
                begin
                    a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
                    all = a0 ^ a1 ^ a2 ^ a3;
                    t[4*c]   = a0 ^ all ^ dbl(a0 ^ a1);
                    t[4*c+1] = a1 ^ all ^ dbl(a1 ^ a2);
                    t[4*c+2] = a2 ^ all ^ dbl(a2 ^ a3);
                    t[4*c+3] = a3 ^ all ^ dbl(a3 ^ a0);
                end
            for (int i = 0; i < 16; i++)
                st[i] = t[i] ^ rk[i];
        end
        for (int i = 0; i < 16; i++)
            o[127-8*i -: 8] = st[i];
        return o;
    endfunction

    // CCM MIC of one telegram: AES(AES(B0) ^ B1) ^ AES(A0), first four bytes.
    function automatic logic [31:0] telegram_mic(input actc_pkg::item_t tg);
        logic [127:0] a0_blk, b0_blk, b1_blk, x2, s0, key;
        logic [103:0] nonce;
        key = {tg.key_high, tg.key_low};
        for (int i = 0; i < 6; i++)
            nonce[103-8*i -: 8] = tg.device_address[8*i +: 8];
        for (int i = 0; i < 4; i++)
            nonce[55-8*i -: 8] = tg.sequence_counter[8*i +: 8];
        nonce[23:0] = 24'h0;
        a0_blk = {actc_pkg::A0_FLAG, nonce, 16'h0000};
        b0_blk = {actc_pkg::B0_FLAG, nonce, 16'h0000};
        b1_blk = {actc_pkg::AAD_LEN, tg.telegram_length, tg.ad_type,
                  tg.manufacturer_id[7:0], tg.manufacturer_id[15:8],
                  tg.sequence_counter[7:0], tg.sequence_counter[15:8],
                  tg.sequence_counter[23:16], tg.sequence_counter[31:24],
                  tg.switch_status, 40'h0};
        x2 = aes_encrypt(key, aes_encrypt(key, b0_blk) ^ b1_blk);
        s0 = aes_encrypt(key, a0_blk);
        return x2[127:96] ^ s0[127:96];
    endfunction

    function automatic actc_pkg::item_t make_telegram(input logic [127:0] key,
                                                      input logic [47:0] addr,
                                                      input logic [31:0] seq,
                                                      input logic [7:0] len,
                                                      input logic [7:0] typ,
                                                      input logic [15:0] mfr,
                                                      input logic [7:0] status,
                                                      input logic [31:0] sig);
        actc_pkg::item_t tg;
        tg.key_high           = key[127:64];
        tg.key_low            = key[63:0];
        tg.device_address     = addr;
        tg.sequence_counter   = seq;
        tg.telegram_length    = len;
        tg.ad_type            = typ;
        tg.manufacturer_id    = mfr;
        tg.switch_status      = status;
        tg.received_signature = sig;
        return tg;
    endfunction

    function automatic actc_pkg::item_t random_telegram();
        actc_pkg::item_t tg;
        tg = make_telegram({$urandom, $urandom, $urandom, $urandom},
                           48'({$urandom, $urandom}), $urandom, 8'($urandom),
                           8'($urandom), 16'($urandom), 8'($urandom), $urandom);
        // Typical headers most of the time, fully random otherwise.
        if ($urandom_range(0, 3) != 0)
        begin
            tg.telegram_length = 8'(8'h0c + $urandom_range(0, 4));
            tg.ad_type         = 8'hff;
        end
        return tg;
    endfunction

    // ------------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------------
    task automatic send_telegram(input actc_pkg::item_t tg);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= tg;
        do
            @(posedge clk);
        while (!in_ch.ready);
        // transfer taken at this edge
        expected_tags.push_back('{signature_ok: telegram_mic(tg) == tg.received_signature,
                                  computed_tag: telegram_mic(tg)});
        telegrams_sent++;
    endtask

    task automatic wait_for_drain();
        in_ch.valid <= 1'b0;
        while (expected_tags.size() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Receiver: random stalls, in-order compare
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        logic    rdy_next;
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            out_stall = 0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                tags_seen++;
                if (expected_tags.size() == 0)
                begin
                    $error("result with nothing expected: tag %h", out_ch.data.computed_tag);
                    mismatches++;
                end
                else
                begin
                    want = expected_tags.pop_front();
                    if (out_ch.data.signature_ok)
                        tags_matched++;
                    if (out_ch.data.signature_ok !== want.signature_ok)
                    begin
                        $error("signature_ok: expected %b, got %b",
                               want.signature_ok, out_ch.data.signature_ok);
                        mismatches++;
                    end
                    if (out_ch.data.computed_tag !== want.computed_tag)
                    begin
                        $error("computed_tag: expected %h, got %h",
                               want.computed_tag, out_ch.data.computed_tag);
                        mismatches++;
                    end
                end
                out_stall = no_idle ? 0 : $urandom_range(0, MAX_WAIT);
            end
            if (out_stall > 0)
            begin
                out_stall--;
                rdy_next = 1'b0;
            end
            else
                rdy_next = 1'b1;
            out_ch.ready <= rdy_next;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin
        telegram_row_t dir_rows [$];
        actc_pkg::item_t tg;
        int    waited;

        in_ch.valid = 1'b0;
        in_ch.data  = '0;
        mismatches = 0;
        tags_seen = 0;
        tags_matched = 0;
        telegrams_sent = 0;
        no_idle = 1'b0;

        // Directed table: field extremes, all-zero key, matching and
        // non-matching signatures.
        dir_rows.push_back('{make_telegram('0, '0, '0, '0, '0, '0, '0, '0), 1'b0});
        dir_rows.push_back('{make_telegram('0, '0, '0, '0, '0, '0, '0, '0), 1'b1});
        dir_rows.push_back('{make_telegram('1, '1, '1, '1, '1, '1, '1, '1), 1'b0});
        dir_rows.push_back('{make_telegram('1, '1, '1, '1, '1, '1, '1, '1), 1'b1});
        dir_rows.push_back('{make_telegram({16{8'haa}}, {6{8'h55}}, 32'h55aa55aa,
                             8'haa, 8'h55, 16'haa55, 8'h55, 32'haaaa5555), 1'b0});
        dir_rows.push_back('{make_telegram({16{8'h55}}, {6{8'haa}}, 32'haa55aa55,
                             8'h55, 8'haa, 16'h55aa, 8'haa, 32'h5555aaaa), 1'b1});
        dir_rows.push_back('{make_telegram('0, 48'hffffffffffff, 32'h0, 8'h0c, 8'hff,
                             16'h03da, 8'h01, '0), 1'b1});
        dir_rows.push_back('{make_telegram(128'h000102030405060708090a0b0c0d0e0f,
                             48'h000000000001, 32'hffffffff, 8'h0c, 8'hff,
                             16'h03da, 8'h80, '0), 1'b1});
        dir_rows.push_back('{make_telegram(128'h80000000000000000000000000000001,
                             48'h800000000000, 32'h80000001, 8'h01, 8'h80,
                             16'h8001, 8'hfe, 32'h00000001), 1'b0});
        dir_rows.push_back('{make_telegram(128'h2b7e151628aed2a6abf7158809cf4f3c,
                             48'he215000019b8, 32'h0000005d, 8'h0c, 8'hff,
                             16'h03da, 8'h11, '0), 1'b1});

        @(posedge rst_n);
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            tg = dir_rows[i].tlg;
            if (dir_rows[i].good_sig)
                tg.received_signature = telegram_mic(tg);
            send_telegram(tg);
        end

        // Let the pipe empty before the random part.
        wait_for_drain();

        for (int n = 0; n < RANDOM_TELEGRAMS; n++)
        begin
            // Bursts with no idling on either side now and then.
            if (n % 60 == 0)
                no_idle = ($urandom_range(0, 2) == 0);
            tg = random_telegram();
            case ($urandom_range(0, 3))
                0: tg.received_signature = telegram_mic(tg);
                1: tg.received_signature = telegram_mic(tg) ^ (32'h1 << $urandom_range(0, 31));
                default: ;
            endcase
            send_telegram(tg);
            if (n == RANDOM_TELEGRAMS / 2)
                wait_for_drain();
        end
        in_ch.valid <= 1'b0;
        no_idle = 1'b0;

        waited = 0;
        while (expected_tags.size() != 0 && waited < 100000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Checked %0d telegrams (%0d results, %0d with a matching signature).",
                 telegrams_sent, tags_seen, tags_matched);
        if (expected_tags.size() != 0)
        begin
            $error("%0d results never arrived", expected_tags.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule
`default_nettype wire
